### hdl/nmea_ck_pkg.sv
// Shared constants, types and a helper function for the NMEA sentence checksum framer.
package nmea_ck_pkg;

    localparam logic [7:0] START_MARK      = 8'h24;
    localparam logic [7:0] END_MARK        = 8'h2A;
    localparam logic [7:0] MAX_LEN_DEFAULT = 8'd128;

    typedef enum logic [1:0] {
        ST_VALID    = 2'd0,
        ST_MISMATCH = 2'd1,
        ST_BADHEX   = 2'd2,
        ST_OVERFLOW = 2'd3
    } status_t;

    typedef struct packed {
        logic       ok;
        logic [3:0] val;
    } hex_t;

    // Decodes one ASCII hex digit; upper and lower case letters are both accepted.
    function automatic hex_t hex_decode(input logic [7:0] c);
        hex_t res;
        res.ok  = 1'b0;
        res.val = 4'd0;
        if (c >= 8'h30 && c <= 8'h39) begin
            res.ok  = 1'b1;
            res.val = 4'(c - 8'h30);
        end else if (c >= 8'h41 && c <= 8'h46) begin
            res.ok  = 1'b1;
            res.val = 4'(c - 8'h37);
        end else if (c >= 8'h61 && c <= 8'h66) begin
            res.ok  = 1'b1;
            res.val = 4'(c - 8'h57);
        end
        return res;
    endfunction

endpackage

### hdl/nmea_sentence_checksum_framer_core.sv
// Top level of the NMEA sentence checksum framer: framing state machine, input register and result register.

// The framer takes one received character per transaction on the s_ channel and
// sustains one character per clock while the m_ channel keeps up. A character is
// first captured in an input register. Once the result register is free, the
// framing logic (start-mark hunt, body XOR and length count, two hex checksum
// digits) updates the sentence state. When a sentence finishes, the same edge
// loads the result register, so m_valid rises as the last character is consumed.
// Each finished sentence yields exactly one result transaction: valid, checksum
// mismatch, bad hex digit (received_sum reads 0), or overflow when a body byte
// arrives while the body already holds max_sentence_len bytes (received_sum
// reads 0, body_len and computed_sum as counted so far). A '$' in a body
// restarts the sentence without a result; a '$' in place of a checksum digit
// reports a bad digit and also starts a new sentence. While a finished result
// waits in the result register, the character in the input register waits with
// it. The input register can still take one more character if it is empty, and
// after that s_ready stays low until m_ready takes the result. The length limit
// resets to 128 and should only be rewritten while no characters are in flight.
module nmea_sentence_checksum_framer_core (
    input  logic       aclk,
    input  logic       aresetn,

    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_rx_byte,

    output logic       m_valid,
    input  logic       m_ready,
    output logic [1:0] m_sentence_status,
    output logic [7:0] m_body_len,
    output logic [7:0] m_computed_sum,
    output logic [7:0] m_received_sum,

    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic [7:0] cfg_max_sentence_len
);

    typedef enum logic [1:0] {
        PH_HUNT = 2'd0,
        PH_BODY = 2'd1,
        PH_HEX1 = 2'd2,
        PH_HEX2 = 2'd3
    } phase_t;

    // Sentence state.
    phase_t     phase_reg,        phase_next;
    logic [7:0] running_xor_reg,  running_xor_next;
    logic [7:0] length_count_reg, length_count_next;
    logic [3:0] high_nibble_reg,  high_nibble_next;
    logic [7:0] max_len_reg,      max_len_next;

    // Input register.
    logic       in_valid_reg,     in_valid_next;
    logic [7:0] in_byte_reg,      in_byte_next;

    // Result register.
    logic       out_valid_reg,    out_valid_next;
    logic [1:0] out_status_reg,   out_status_next;
    logic [7:0] out_len_reg,      out_len_next;
    logic [7:0] out_csum_reg,     out_csum_next;
    logic [7:0] out_rsum_reg,     out_rsum_next;

    logic                 out_free;
    logic                 proc;
    nmea_ck_pkg::hex_t    hex;
    logic                 is_start;
    logic                 is_end;

    // The character in the input register is processed whenever the result
    // register can take a possible result in the same edge.
    assign out_free = !out_valid_reg || m_ready;
    assign proc     = in_valid_reg && out_free;
    assign s_ready  = !in_valid_reg || out_free;
    assign cfg_ready = 1'b1;

    assign hex      = nmea_ck_pkg::hex_decode(in_byte_reg);
    assign is_start = (in_byte_reg == nmea_ck_pkg::START_MARK);
    assign is_end   = (in_byte_reg == nmea_ck_pkg::END_MARK);

    always_comb begin
        phase_next        = phase_reg;
        running_xor_next  = running_xor_reg;
        length_count_next = length_count_reg;
        high_nibble_next  = high_nibble_reg;
        max_len_next      = max_len_reg;

        in_valid_next     = in_valid_reg;
        in_byte_next      = in_byte_reg;

        out_valid_next    = out_valid_reg && !m_ready;
        out_status_next   = out_status_reg;
        out_len_next      = out_len_reg;
        out_csum_next     = out_csum_reg;
        out_rsum_next     = out_rsum_reg;

        if (cfg_valid) begin
            max_len_next = cfg_max_sentence_len;
        end

        if (s_ready) begin
            in_valid_next = s_valid;
            if (s_valid) begin
                in_byte_next = s_rx_byte;
            end
        end

        if (proc) begin
            // Sentence fields are sampled before this character updates them.
            out_len_next  = length_count_reg;
            out_csum_next = running_xor_reg;
            out_rsum_next = 8'd0;
            case (phase_reg)
                PH_HUNT: begin
                    if (is_start) begin
                        phase_next        = PH_BODY;
                        running_xor_next  = 8'd0;
                        length_count_next = 8'd0;
                        high_nibble_next  = 4'd0;
                    end
                end
                PH_BODY: begin
                    if (is_start) begin
                        running_xor_next  = 8'd0;
                        length_count_next = 8'd0;
                        high_nibble_next  = 4'd0;
                    end else if (is_end) begin
                        phase_next = PH_HEX1;
                    end else if (length_count_reg >= max_len_reg) begin
                        // The offending byte is dropped along with the sentence.
                        out_valid_next  = 1'b1;
                        out_status_next = nmea_ck_pkg::ST_OVERFLOW;
                        phase_next      = PH_HUNT;
                    end else begin
                        running_xor_next  = running_xor_reg ^ in_byte_reg;
                        length_count_next = length_count_reg + 8'd1;
                    end
                end
                PH_HEX1, PH_HEX2: begin
                    if (!hex.ok) begin
                        out_valid_next  = 1'b1;
                        out_status_next = nmea_ck_pkg::ST_BADHEX;
                        phase_next      = PH_HUNT;
                        if (is_start) begin
                            phase_next        = PH_BODY;
                            running_xor_next  = 8'd0;
                            length_count_next = 8'd0;
                            high_nibble_next  = 4'd0;
                        end
                    end else if (phase_reg == PH_HEX1) begin
                        high_nibble_next = hex.val;
                        phase_next       = PH_HEX2;
                    end else begin
                        out_valid_next  = 1'b1;
                        out_rsum_next   = {high_nibble_reg, hex.val};
                        out_status_next = ({high_nibble_reg, hex.val} == running_xor_reg) ?
                                          nmea_ck_pkg::ST_VALID : nmea_ck_pkg::ST_MISMATCH;
                        phase_next      = PH_HUNT;
                    end
                end
                default: begin
                    phase_next = PH_HUNT;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg        <= PH_HUNT;
            running_xor_reg  <= 8'd0;
            length_count_reg <= 8'd0;
            high_nibble_reg  <= 4'd0;
            max_len_reg      <= nmea_ck_pkg::MAX_LEN_DEFAULT;
            in_valid_reg     <= 1'b0;
            out_valid_reg    <= 1'b0;
        end else begin
            phase_reg        <= phase_next;
            running_xor_reg  <= running_xor_next;
            length_count_reg <= length_count_next;
            high_nibble_reg  <= high_nibble_next;
            max_len_reg      <= max_len_next;
            in_valid_reg     <= in_valid_next;
            out_valid_reg    <= out_valid_next;
        end
        in_byte_reg    <= in_byte_next;
        out_status_reg <= out_status_next;
        out_len_reg    <= out_len_next;
        out_csum_reg   <= out_csum_next;
        out_rsum_reg   <= out_rsum_next;
    end

    assign m_valid           = out_valid_reg;
    assign m_sentence_status = out_status_reg;
    assign m_body_len        = out_len_reg;
    assign m_computed_sum    = out_csum_reg;
    assign m_received_sum    = out_rsum_reg;

    // A new result can only appear after a character was held in the input register.
    a_result_has_source: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(out_valid_reg) |-> $past(in_valid_reg))
        else $error("result appeared without a processed character");

    // A valid status means the two sums agree.
    a_valid_sums_match: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && out_status_reg == nmea_ck_pkg::ST_VALID)
        |-> (out_csum_reg == out_rsum_reg))
        else $error("valid status with differing sums");

    // Bad digit and overflow results carry no received checksum.
    a_error_rsum_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && (out_status_reg == nmea_ck_pkg::ST_BADHEX ||
                           out_status_reg == nmea_ck_pkg::ST_OVERFLOW))
        |-> (out_rsum_reg == 8'd0))
        else $error("error result with nonzero received checksum");

    // A processed start mark always opens a fresh, empty body.
    a_start_restarts: assert property (@(posedge aclk) disable iff (!aresetn)
        (proc && is_start) |=> (phase_reg == PH_BODY && length_count_reg == 8'd0 &&
                                running_xor_reg == 8'd0))
        else $error("start mark did not restart the sentence");

endmodule
